[design/gcdb_pkg.sv]
// ----------------------------------------------------------------------------
// gcdb_pkg
// Shared widths, fixed-point constants, pipeline latencies and the CORDIC
// arctangent table for the great-circle distance and bearing block.
// ----------------------------------------------------------------------------
package gcdb_pkg;

  // Number of CORDIC micro-rotations, one pipeline stage each.
  localparam int CORDIC_STEPS = 30;

  // Signed width of the CORDIC datapaths (x, y and angle).
  localparam int CW = 36;

  // Width of the sine and cosine leaving the rotation units.
  localparam int SCW = 33;

  // Angle constants in units of 1e-7 degree.
  localparam logic signed [33:0] FULL_TURN_U    = 34'sd3600000000;
  localparam logic signed [33:0] HALF_TURN_U    = 34'sd1800000000;
  localparam logic signed [33:0] QUARTER_TURN_U = 34'sd900000000;

  // Fixed-point constants, Q30 unless stated.
  localparam logic [31:0] PI_Q30 = 32'd3373259426;
  localparam logic signed [CW-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [CW-1:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 36'sd652032874;
  localparam logic signed [63:0] ONE_Q60 = 64'sh1000_0000_0000_0000;
  localparam logic [25:0] DIST_MAX = 26'h3FF_FFFF;

  // Divisor and rounding offset of the degree to radian conversion.
  localparam logic [31:0] HALF_TURN_DIV = 32'd1800000000;
  localparam logic [31:0] HALF_TURN_RND = 32'd900000000;

  // Reciprocal estimate floor(PI_Q30 * 2^32 / 1.8e9) for the conversion.
  localparam logic [63:0] RECIP_FULL = {PI_Q30, 32'd0} / 64'd1800000000;
  localparam logic [32:0] RECIP = RECIP_FULL[32:0];

  // Default sphere radius in metres.
  localparam logic [23:0] RADIUS_RESET = 24'd6371000;

  // Pipeline latencies of the sub-units and of the whole block.
  localparam int SC_LAT  = CORDIC_STEPS + 4;
  localparam int ISQ_LAT = 31;
  localparam int AT_LAT  = CORDIC_STEPS + 2;
  localparam int TOT_LAT = SC_LAT + ISQ_LAT + AT_LAT + 6;

  // atan(2^-i) in Q30 radians.
  function automatic logic [29:0] atan_q30(input int idx);
    logic [29:0] v;
    case (idx)
      0:  v = 30'd843314856;
      1:  v = 30'd497837829;
      2:  v = 30'd263043836;
      3:  v = 30'd133525158;
      4:  v = 30'd67021686;
      5:  v = 30'd33543515;
      6:  v = 30'd16775850;
      7:  v = 30'd8388437;
      8:  v = 30'd4194282;
      9:  v = 30'd2097149;
      10: v = 30'd1048575;
      11: v = 30'd524287;
      12: v = 30'd262143;
      13: v = 30'd131071;
      14: v = 30'd65535;
      15: v = 30'd32767;
      16: v = 30'd16383;
      17: v = 30'd8191;
      18: v = 30'd4095;
      19: v = 30'd2047;
      20: v = 30'd1023;
      21: v = 30'd511;
      22: v = 30'd255;
      23: v = 30'd127;
      24: v = 30'd63;
      25: v = 30'd31;
      26: v = 30'd15;
      27: v = 30'd8;
      28: v = 30'd4;
      29: v = 30'd2;
      30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

[design/gcdb_sincos.sv]
// ----------------------------------------------------------------------------
// gcdb_sincos
// Pipelined sine and cosine of an angle in 1e-7 degree units: quadrant fold,
// exact rounded conversion to Q30 radians, then a rotation CORDIC.
// ----------------------------------------------------------------------------
module gcdb_sincos (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [32:0]                ang,
  output logic signed [gcdb_pkg::SCW-1:0]   sin_out,
  output logic signed [gcdb_pkg::SCW-1:0]   cos_out
);

  localparam int CW = gcdb_pkg::CW;
  localparam int N  = gcdb_pkg::CORDIC_STEPS;

  // Fold into one quadrant around zero; a half-turn fold negates both.
  logic signed [33:0] a_ext;
  logic signed [33:0] a_fold;
  logic signed [33:0] a_mag;
  logic               fold_neg;

  always_comb begin
    a_ext    = {ang[32], ang};
    a_fold   = a_ext;
    fold_neg = 1'b0;
    if (a_ext > gcdb_pkg::QUARTER_TURN_U) begin
      a_fold   = a_ext - gcdb_pkg::HALF_TURN_U;
      fold_neg = 1'b1;
    end else if (a_ext < -gcdb_pkg::QUARTER_TURN_U) begin
      a_fold   = a_ext + gcdb_pkg::HALF_TURN_U;
      fold_neg = 1'b1;
    end
    a_mag = a_fold[33] ? -a_fold : a_fold;
  end

  // Stage 1: reciprocal estimate and exact numerator.
  logic [62:0] d1_pc;
  logic [62:0] d1_n;
  logic        d1_neg;
  logic        d1_sgn;

  always_ff @(posedge clk) begin
    if (en) begin
      d1_pc  <= 63'(a_mag[29:0]) * 63'(gcdb_pkg::RECIP);
      d1_n   <= 63'(a_mag[29:0]) * 63'(gcdb_pkg::PI_Q30) + 63'(gcdb_pkg::HALF_TURN_RND);
      d1_neg <= fold_neg;
      d1_sgn <= a_fold[33];
    end
  end

  // Stage 2: quotient estimate, which is the true quotient or one below.
  logic [63:0] pc_rnd;
  logic [30:0] qe;
  logic [62:0] d2_t;
  logic [62:0] d2_n;
  logic [30:0] d2_qe;
  logic        d2_neg;
  logic        d2_sgn;

  assign pc_rnd = {1'b0, d1_pc} + 64'h8000_0000;
  assign qe     = pc_rnd[62:32];

  always_ff @(posedge clk) begin
    if (en) begin
      d2_t   <= (63'(qe) + 63'd1) * 63'(gcdb_pkg::HALF_TURN_DIV);
      d2_n   <= d1_n;
      d2_qe  <= qe;
      d2_neg <= d1_neg;
      d2_sgn <= d1_sgn;
    end
  end

  // Stage 3: correct the quotient and start the rotation.
  logic [30:0]          q_fix;
  logic signed [CW-1:0] z_pos;

  assign q_fix = (d2_t <= d2_n) ? (d2_qe + 31'd1) : d2_qe;
  assign z_pos = CW'(q_fix);

  logic signed [CW-1:0] cx [0:N];
  logic signed [CW-1:0] cy [0:N];
  logic signed [CW-1:0] cz [0:N];
  logic                 cn [0:N];

  always_ff @(posedge clk) begin
    if (en) begin
      cx[0] <= gcdb_pkg::CORDIC_GAIN_Q30;
      cy[0] <= '0;
      cz[0] <= d2_sgn ? -z_pos : z_pos;
      cn[0] <= d2_neg;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    localparam logic signed [CW-1:0] AT = CW'(gcdb_pkg::atan_q30(i));
    always_ff @(posedge clk) begin
      if (en) begin
        if (cz[i] >= 0) begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - AT;
        end else begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + AT;
        end
        cn[i+1] <= cn[i];
      end
    end
  end

  // Final stage: undo the half-turn fold.
  logic signed [CW-1:0] s_fin;
  logic signed [CW-1:0] c_fin;

  assign s_fin = cn[N] ? -cy[N] : cy[N];
  assign c_fin = cn[N] ? -cx[N] : cx[N];

  always_ff @(posedge clk) begin
    if (en) begin
      sin_out <= s_fin[gcdb_pkg::SCW-1:0];
      cos_out <= c_fin[gcdb_pkg::SCW-1:0];
    end
  end

endmodule

[design/gcdb_isqrt.sv]
// ----------------------------------------------------------------------------
// gcdb_isqrt
// Pipelined floor square root of a 62-bit value, one result bit per stage.
// ----------------------------------------------------------------------------
module gcdb_isqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [61:0] val,
  output logic [31:0] root
);

  localparam int S = gcdb_pkg::ISQ_LAT;

  logic [62:0] rv [0:S];
  logic [62:0] rr [0:S];

  assign rv[0] = 63'(val);
  assign rr[0] = '0;

  for (genvar k = 0; k < S; k++) begin : g_step
    localparam logic [62:0] B = 63'(1) << (60 - 2 * k);
    always_ff @(posedge clk) begin
      if (en) begin
        if (rv[k] >= rr[k] + B) begin
          rv[k+1] <= rv[k] - (rr[k] + B);
          rr[k+1] <= (rr[k] >> 1) + B;
        end else begin
          rv[k+1] <= rv[k];
          rr[k+1] <= rr[k] >> 1;
        end
      end
    end
  end

  assign root = rr[S][31:0];

endmodule

[design/gcdb_atan2.sv]
// ----------------------------------------------------------------------------
// gcdb_atan2
// Pipelined atan2 by vectoring CORDIC, Q30 radians; a zero vector gives zero.
// ----------------------------------------------------------------------------
module gcdb_atan2 (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [gcdb_pkg::CW-1:0]  y_in,
  input  logic signed [gcdb_pkg::CW-1:0]  x_in,
  output logic signed [gcdb_pkg::CW-1:0]  ang
);

  localparam int CW = gcdb_pkg::CW;
  localparam int N  = gcdb_pkg::CORDIC_STEPS;

  logic signed [CW-1:0] vx [0:N];
  logic signed [CW-1:0] vy [0:N];
  logic signed [CW-1:0] vz [0:N];
  logic                 vzero [0:N];

  // Pre-rotation by a quarter turn brings x into the right half plane.
  always_ff @(posedge clk) begin
    if (en) begin
      vzero[0] <= (x_in == 0) && (y_in == 0);
      if (x_in < 0) begin
        if (y_in >= 0) begin
          vx[0] <= y_in;
          vy[0] <= -x_in;
          vz[0] <= gcdb_pkg::HALF_PI_Q30;
        end else begin
          vx[0] <= -y_in;
          vy[0] <= x_in;
          vz[0] <= -gcdb_pkg::HALF_PI_Q30;
        end
      end else begin
        vx[0] <= x_in;
        vy[0] <= y_in;
        vz[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_vec
    localparam logic signed [CW-1:0] AT = CW'(gcdb_pkg::atan_q30(i));
    always_ff @(posedge clk) begin
      if (en) begin
        if (vy[i] >= 0) begin
          vx[i+1] <= vx[i] + (vy[i] >>> i);
          vy[i+1] <= vy[i] - (vx[i] >>> i);
          vz[i+1] <= vz[i] + AT;
        end else begin
          vx[i+1] <= vx[i] - (vy[i] >>> i);
          vy[i+1] <= vy[i] + (vx[i] >>> i);
          vz[i+1] <= vz[i] - AT;
        end
        vzero[i+1] <= vzero[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang <= vzero[N] ? '0 : vz[N];
    end
  end

endmodule

[design/great_circle_distance_bearing.sv]
// ----------------------------------------------------------------------------
// great_circle_distance_bearing
// Path: an accepted item reaches its result through the two CORDIC chains and
// the 31-stage square root.
// Throughput: one item per cycle; the whole pipeline advances whenever the
// output register is empty or its result is being taken.
// Reset: rst (synchronous) empties the pipeline and loads the radius 6371000.
// ----------------------------------------------------------------------------
module great_circle_distance_bearing (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [23:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [30:0] start_lat,
  input  logic signed [31:0] start_lng,
  input  logic signed [30:0] end_lat,
  input  logic signed [31:0] end_lng,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [25:0] surface_distance,
  output logic [30:0] bearing_angle
);

  localparam int CW  = gcdb_pkg::CW;
  localparam int SCW = gcdb_pkg::SCW;
  localparam int TOT = gcdb_pkg::TOT_LAT;
  localparam int DLY = gcdb_pkg::ISQ_LAT + 1;

  // The sphere radius is to be rewritten by the user only while the pipeline is empty,
  // so the output stage may read it directly; the block itself does not enforce this.
  logic [23:0] radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= gcdb_pkg::RADIUS_RESET;
    end else if (cfg_we) begin
      radius <= cfg_wdata;
    end
  end

  // One global advance signal: every stage moves together, and an item is
  // held in place whenever the final result is waiting to be taken.
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Valid bits and the coincident-point flag travel alongside the data.
  logic [TOT-1:0] vld;
  logic [TOT-1:0] coin_sr;

  // Input stage: longitude difference reduced into one turn around zero,
  // and the coincident-point test on the raw latitude fields.
  logic signed [33:0] dlng;
  logic signed [33:0] dlng_red;
  logic               coin_in;

  always_comb begin
    dlng     = {{2{end_lng[31]}}, end_lng} - {{2{start_lng[31]}}, start_lng};
    dlng_red = dlng;
    if (dlng >= gcdb_pkg::HALF_TURN_U) begin
      dlng_red = dlng - gcdb_pkg::FULL_TURN_U;
    end else if (dlng < -gcdb_pkg::HALF_TURN_U) begin
      dlng_red = dlng + gcdb_pkg::FULL_TURN_U;
    end
    coin_in = (start_lat == end_lat) && (dlng_red == 0);
  end

  logic signed [32:0] s1_lat1;
  logic signed [32:0] s1_lat2;
  logic signed [32:0] s1_dl;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[TOT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      coin_sr <= {coin_sr[TOT-2:0], coin_in};
      s1_lat1 <= 33'(start_lat);
      s1_lat2 <= 33'(end_lat);
      s1_dl   <= dlng_red[32:0];
    end
  end

  assign out_valid = vld[TOT-1];

  // Sine and cosine of both latitudes and of the longitude difference.
  logic signed [SCW-1:0] s1, c1, s2, c2, sd, cd;

  gcdb_sincos u_sc_lat1 (.clk(clk), .en(en), .ang(s1_lat1), .sin_out(s1), .cos_out(c1));
  gcdb_sincos u_sc_lat2 (.clk(clk), .en(en), .ang(s1_lat2), .sin_out(s2), .cos_out(c2));
  gcdb_sincos u_sc_dlng (.clk(clk), .en(en), .ang(s1_dl),   .sin_out(sd), .cos_out(cd));

  // First product stage: the five pairwise products used later, in Q60.
  logic signed [65:0] m_ss, m_cc, m_sdc2, m_c1s2, m_s1c2;
  logic signed [63:0] p_ss, p_cc, p_sdc2, p_c1s2, p_s1c2;
  logic signed [SCW-1:0] p_cd;

  assign m_ss   = s1 * s2;
  assign m_cc   = c1 * c2;
  assign m_sdc2 = sd * c2;
  assign m_c1s2 = c1 * s2;
  assign m_s1c2 = s1 * c2;

  always_ff @(posedge clk) begin
    if (en) begin
      p_ss   <= m_ss[63:0];
      p_cc   <= m_cc[63:0];
      p_sdc2 <= m_sdc2[63:0];
      p_c1s2 <= m_c1s2[63:0];
      p_s1c2 <= m_s1c2[63:0];
      p_cd   <= cd;
    end
  end

  // Second product stage: the terms that scale by cos of the longitude difference
  // give the central angle's cosine and bearing x term in Q60; bearing y is Q30.
  logic signed [63:0] cc30_w, s1c2_30_w;
  logic signed [33:0] cc30, s1c2_30;
  logic signed [66:0] m_ccd, m_scd;
  logic signed [63:0] q_x60, q_bxi;
  logic signed [63:0] q_by_w;
  logic signed [CW-1:0] q_by;

  assign cc30_w    = p_cc >>> 30;
  assign s1c2_30_w = p_s1c2 >>> 30;
  assign cc30      = cc30_w[33:0];
  assign s1c2_30   = s1c2_30_w[33:0];
  assign m_ccd     = cc30 * p_cd;
  assign m_scd     = s1c2_30 * p_cd;
  assign q_by_w    = p_sdc2 >>> 30;

  always_ff @(posedge clk) begin
    if (en) begin
      q_x60 <= p_ss + m_ccd[63:0];
      q_bxi <= p_c1s2 - m_scd[63:0];
      q_by  <= q_by_w[CW-1:0];
    end
  end

  // Third stage: clamp to [-1, 1] and form 1 - x and 1 + x for the roots.
  logic signed [63:0] x_cl, one_m, one_p, xq_w, bx_w;
  logic [61:0] r_va, r_vb;

  always_comb begin
    x_cl = q_x60;
    if (q_x60 > gcdb_pkg::ONE_Q60) begin
      x_cl = gcdb_pkg::ONE_Q60;
    end else if (q_x60 < -gcdb_pkg::ONE_Q60) begin
      x_cl = -gcdb_pkg::ONE_Q60;
    end
    one_m = gcdb_pkg::ONE_Q60 - x_cl;
    one_p = gcdb_pkg::ONE_Q60 + x_cl;
    xq_w  = x_cl >>> 30;
    bx_w  = q_bxi >>> 30;
  end

  // Side values wait alongside the square roots; entry 0 is this stage.
  logic signed [CW-1:0] d_xq [0:DLY];
  logic signed [CW-1:0] d_by [0:DLY];
  logic signed [CW-1:0] d_bx [0:DLY];

  always_ff @(posedge clk) begin
    if (en) begin
      r_va    <= one_m[61:0];
      r_vb    <= one_p[61:0];
      d_xq[0] <= xq_w[CW-1:0];
      d_by[0] <= q_by;
      d_bx[0] <= bx_w[CW-1:0];
      for (int k = 1; k <= DLY; k++) begin
        d_xq[k] <= d_xq[k-1];
        d_by[k] <= d_by[k-1];
        d_bx[k] <= d_bx[k-1];
      end
    end
  end

  // Sine of the central angle as sqrt(1 - x) * sqrt(1 + x).
  logic [31:0] sq_a, sq_b;

  gcdb_isqrt u_isq_a (.clk(clk), .en(en), .val(r_va), .root(sq_a));
  gcdb_isqrt u_isq_b (.clk(clk), .en(en), .val(r_vb), .root(sq_b));

  logic [63:0] m_sab;
  logic signed [CW-1:0] sin_c;

  assign m_sab = 64'(sq_a) * 64'(sq_b);

  always_ff @(posedge clk) begin
    if (en) begin
      sin_c <= CW'(m_sab[63:30]);
    end
  end

  // Central angle and initial bearing, run side by side.
  logic signed [CW-1:0] ang_c, ang_b;

  gcdb_atan2 u_at_central (.clk(clk), .en(en), .y_in(sin_c), .x_in(d_xq[DLY]),
                           .ang(ang_c));
  gcdb_atan2 u_at_bearing (.clk(clk), .en(en), .y_in(d_by[DLY]), .x_in(d_bx[DLY]),
                           .ang(ang_b));

  // Output stage: scale the angle by the radius with rounding and
  // saturation, wrap the bearing into one turn before quantising it, and zero both for coincident points.
  logic [32:0]          ang_pos;
  logic [56:0]          dist_prod;
  logic [26:0]          dist_raw;
  logic [25:0]          dist_fin;
  logic signed [CW-1:0] b_w;
  logic signed [CW-1:0] b_rnd;
  logic [33:0]          bq;
  logic [30:0]          bear_fin;
  logic                 coin_o;

  always_comb begin
    ang_pos   = (ang_c < 0) ? 33'd0 : ang_c[32:0];
    dist_prod = 57'(ang_pos) * 57'(radius) + 57'(32'h2000_0000);
    dist_raw  = dist_prod[56:30];
    dist_fin  = (dist_raw > 27'(gcdb_pkg::DIST_MAX)) ? gcdb_pkg::DIST_MAX : dist_raw[25:0];

    b_w = ang_b;
    if (b_w < 0) begin
      b_w = b_w + gcdb_pkg::TWO_PI_Q30;
    end
    if (b_w >= gcdb_pkg::TWO_PI_Q30) begin
      b_w = b_w - gcdb_pkg::TWO_PI_Q30;
    end
    if (b_w < 0) begin
      b_w = '0;
    end
    b_rnd    = b_w + 36'sd2;
    bq       = b_rnd[CW-1:2];
    bear_fin = (bq > 34'(gcdb_pkg::HALF_PI_Q30)) ? 31'd0 : bq[30:0];
    coin_o   = coin_sr[TOT-2];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      surface_distance <= coin_o ? 26'd0 : dist_fin;
      bearing_angle    <= coin_o ? 31'd0 : bear_fin;
    end
  end

  // The bearing never leaves its quarter-scaled full-turn range.
  a_bearing_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (bearing_angle <= 31'd1686629713))
    else $error("bearing outside range");

  // Input is refused only while a finished result is waiting.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without a waiting result");

  // Coincident points give a zero distance and a zero bearing.
  a_coincident: assert property (@(posedge clk) disable iff (rst)
    (out_valid && coin_sr[TOT-1]) |-> (surface_distance == 26'd0 && bearing_angle == 31'd0))
    else $error("coincident item gave a nonzero result");

endmodule
